### rtl/thd_pkg.sv
// ----------------------------------------------------------------------------
// thd_pkg
// Types, codes and helper functions shared by the hold dropout monitor.
// ----------------------------------------------------------------------------
package thd_pkg;

   localparam int unsigned NUM_BINS = 5;
   localparam int unsigned BIN_W    = 3;
   localparam int unsigned EV_W     = 3;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
   localparam logic [EV_W-1:0] EV_START   = 3'd1;
   localparam logic [EV_W-1:0] EV_RELEASE = 3'd2;
   localparam logic [EV_W-1:0] EV_REJOIN  = 3'd3;
   localparam logic [EV_W-1:0] EV_END     = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_ARM_SELECT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_TARGET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REJOIN = 2'd2;

   localparam logic [31:0] HOLD_TARGET_RESET = 32'd10000;
   localparam logic [15:0] REJOIN_RESET      = 16'd100;

   localparam logic [31:0] BIN_EDGE_0 = 32'd10;
   localparam logic [31:0] BIN_EDGE_1 = 32'd25;
   localparam logic [31:0] BIN_EDGE_2 = 32'd50;
   localparam logic [31:0] BIN_EDGE_3 = 32'd100;

   typedef struct packed {
      logic             drop;
      logic             run_end;
      logic             clean;
      logic [31:0]      gap;
      logic [BIN_W-1:0] bin;
   } book_type;

   typedef struct packed {
      logic [31:0] runs;
      logic [31:0] clean;
      logic [31:0] drops;
      logic [31:0] longest;
      logic [31:0] bucket;
   } arm_view_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
   endfunction

   function automatic logic [BIN_W-1:0] gap_bin(input logic [31:0] ms);
      logic [BIN_W-1:0] b;
      if (ms < BIN_EDGE_0) begin
         b = 3'd0;
      end else if (ms < BIN_EDGE_1) begin
         b = 3'd1;
      end else if (ms < BIN_EDGE_2) begin
         b = 3'd2;
      end else if (ms < BIN_EDGE_3) begin
         b = 3'd3;
      end else begin
         b = 3'd4;
      end
      return b;
   endfunction

endpackage

### rtl/touch_hold_dropout_monitor.sv
// ----------------------------------------------------------------------------
// touch_hold_dropout_monitor
// Tracks touch hold runs, dropouts and per-arm statistics from timestamped
// touch samples.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on the req_ channel (req_touched, req_sample_time_ms) and
// every sample gives exactly one item on the rsp_ channel. An item is taken
// at a clock edge where valid is high and stall is low.
// A sample is held in an input register, processed when it advances and the
// result lands in an output register, so rsp_valid rises once the sample has
// moved from the input register into the output register. One item per
// cycle is sustained while rsp_stall is low; the run state and the per-arm
// counters update as each sample is processed, which sets that rate.
// When rsp_stall is high the result register holds and the input register
// keeps its sample; req_stall rises only while both are occupied.
// The csr_ port writes the arm select (0), the minimum hold time (1) and the
// rejoin window (2); write only while no item is in flight.
// Synchronous reset clears the run state, every arm counter and histogram bin
// and restores the register defaults; the block accepts items right after.
// ----------------------------------------------------------------------------
module touch_hold_dropout_monitor #(
   parameter int NUM_ARMS = 2
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_touched,
   input  logic [31:0]                      req_sample_time_ms,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [thd_pkg::EV_W-1:0]         rsp_event_res,
   output logic [31:0]                      rsp_span_ms,
   output logic [thd_pkg::BIN_W-1:0]        rsp_bucket_index,
   output logic [31:0]                      rsp_bucket_count,
   output logic [31:0]                      rsp_run_drop_count,
   output logic [31:0]                      rsp_run_longest_gap_ms,
   output logic [31:0]                      rsp_run_contact_ms,
   output logic                             rsp_goal_reached,
   output logic [31:0]                      rsp_arm_run_count,
   output logic [31:0]                      rsp_arm_clean_count,
   output logic [31:0]                      rsp_arm_drop_count,
   output logic [31:0]                      rsp_arm_longest_gap_ms,
   input  logic                             csr_write,
   input  logic [thd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                      csr_data
);
   import thd_pkg::*;

   localparam int ARM_W = (NUM_ARMS > 1) ? $clog2(NUM_ARMS) : 1;

   logic        arm_select_ff;
   logic [31:0] hold_target_ff;
   logic [15:0] rejoin_ff;

   logic        in_valid_ff, in_valid_in;
   logic        touched_ff;
   logic [31:0] time_ff;
   logic        out_valid_ff, out_valid_in;
   logic        accept_in, advance;

   logic [ARM_W-1:0]  live_arm;
   logic [EV_W-1:0]   event_res;
   logic [31:0]       span_ms;
   logic              goal_reached;
   logic [31:0]       run_drops_next, run_longest_next, contact_next;
   book_type          book;
   arm_view_type      view;

   logic [EV_W-1:0]   event_ff;
   logic [31:0]       span_ff;
   logic [BIN_W-1:0]  bucket_index_ff;
   logic [31:0]       bucket_count_ff;
   logic [31:0]       run_drops_ff, run_longest_ff, contact_ff;
   logic              goal_reached_ff;
   logic [31:0]       arm_runs_ff, arm_clean_ff, arm_drops_ff, arm_longest_ff;

   assign live_arm = (int'(arm_select_ff) >= NUM_ARMS) ? ARM_W'(NUM_ARMS - 1)
                                                       : ARM_W'(arm_select_ff);

   assign advance      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign accept_in    = req_valid && !req_stall;
   assign in_valid_in  = accept_in || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_select_ff  <= 1'b0;
         hold_target_ff <= HOLD_TARGET_RESET;
         rejoin_ff      <= REJOIN_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_ARM_SELECT:  arm_select_ff  <= csr_data[0];
            REG_HOLD_TARGET: hold_target_ff <= csr_data;
            REG_REJOIN:      rejoin_ff      <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_in) begin
         touched_ff <= req_touched;
         time_ff    <= req_sample_time_ms;
      end
   end

   thd_core u_core (
      .clock            (clock),
      .reset            (reset),
      .step             (advance),
      .touched          (touched_ff),
      .now              (time_ff),
      .min_hold_ms      (hold_target_ff),
      .rejoin_window_ms (rejoin_ff),
      .event_res        (event_res),
      .span_ms          (span_ms),
      .goal_reached     (goal_reached),
      .run_drops_next   (run_drops_next),
      .run_longest_next (run_longest_next),
      .contact_next     (contact_next),
      .book             (book)
   );

   thd_arm_stats #(
      .NUM_ARMS (NUM_ARMS),
      .ARM_W    (ARM_W)
   ) u_arm_stats (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .arm   (live_arm),
      .book  (book),
      .view  (view)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         event_ff        <= event_res;
         span_ff         <= span_ms;
         bucket_index_ff <= book.drop ? book.bin : '0;
         bucket_count_ff <= view.bucket;
         run_drops_ff    <= run_drops_next;
         run_longest_ff  <= run_longest_next;
         contact_ff      <= contact_next;
         goal_reached_ff <= goal_reached;
         arm_runs_ff     <= view.runs;
         arm_clean_ff    <= view.clean;
         arm_drops_ff    <= view.drops;
         arm_longest_ff  <= view.longest;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_event_res          = event_ff;
   assign rsp_span_ms            = span_ff;
   assign rsp_bucket_index       = bucket_index_ff;
   assign rsp_bucket_count       = bucket_count_ff;
   assign rsp_run_drop_count     = run_drops_ff;
   assign rsp_run_longest_gap_ms = run_longest_ff;
   assign rsp_run_contact_ms     = contact_ff;
   assign rsp_goal_reached       = goal_reached_ff;
   assign rsp_arm_run_count      = arm_runs_ff;
   assign rsp_arm_clean_count    = arm_clean_ff;
   assign rsp_arm_drop_count     = arm_drops_ff;
   assign rsp_arm_longest_gap_ms = arm_longest_ff;

   a_start_clears_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res == EV_START) |->
         (rsp_run_drop_count == '0 && rsp_run_longest_gap_ms == '0 && rsp_run_contact_ms == '0))
      else $error("run start did not clear the run values");

   a_bucket_only_on_rejoin: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res != EV_REJOIN) |->
         (rsp_bucket_count == '0 && rsp_bucket_index == '0))
      else $error("histogram fields set without a dropout");

   a_met_only_on_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res != EV_END) |-> !rsp_goal_reached)
      else $error("target met flagged outside a run end");

   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("input stalled while the pipeline could advance");

endmodule

### rtl/thd_core.sv
// ----------------------------------------------------------------------------
// thd_core
// Run tracker: holds the state of the current hold run, classifies each
// sample and updates the run state when the sample is processed.
// ----------------------------------------------------------------------------
module thd_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic                       touched,
   input  logic [31:0]                now,
   input  logic [31:0]                min_hold_ms,
   input  logic [15:0]                rejoin_window_ms,
   output logic [thd_pkg::EV_W-1:0]   event_res,
   output logic [31:0]                span_ms,
   output logic                       goal_reached,
   output logic [31:0]                run_drops_next,
   output logic [31:0]                run_longest_next,
   output logic [31:0]                contact_next,
   output thd_pkg::book_type          book
);
   import thd_pkg::*;

   logic        hold_on_ff, hold_on_in;
   logic        dropping_ff, dropping_in;
   logic [31:0] run_begin_ff, run_begin_in;
   logic [31:0] contact_ff;
   logic [31:0] last_down_ff, last_down_in;
   logic [31:0] last_up_ff, last_up_in;
   logic [31:0] run_drops_ff;
   logic [31:0] run_longest_ff;

   logic        is_start, is_rejoin, is_release, is_end;
   logic [31:0] up_gap, total, down_span;
   logic [32:0] contact_sum;
   logic        met;

   assign is_start   = touched && !hold_on_ff && !dropping_ff;
   assign is_rejoin  = hold_on_ff && touched && dropping_ff;
   assign is_release = hold_on_ff && !touched && !dropping_ff;
   assign up_gap     = now - last_up_ff;
   assign is_end     = hold_on_ff && !touched && dropping_ff &&
                       (up_gap > {16'd0, rejoin_window_ms});
   assign total      = last_up_ff - run_begin_ff;
   assign met        = is_end && (total >= min_hold_ms);
   assign down_span  = now - last_down_ff;
   assign contact_sum = {1'b0, contact_ff} + {1'b0, down_span};

   always_comb begin
      hold_on_in       = hold_on_ff;
      dropping_in      = dropping_ff;
      run_begin_in     = run_begin_ff;
      contact_next     = contact_ff;
      last_down_in     = last_down_ff;
      last_up_in       = last_up_ff;
      run_drops_next   = run_drops_ff;
      run_longest_next = run_longest_ff;
      event_res        = EV_NONE;
      span_ms          = '0;
      if (is_start) begin
         hold_on_in       = 1'b1;
         run_begin_in     = now;
         contact_next     = '0;
         last_down_in     = now;
         run_drops_next   = '0;
         run_longest_next = '0;
         event_res        = EV_START;
      end else if (is_rejoin) begin
         dropping_in      = 1'b0;
         last_down_in     = now;
         run_drops_next   = sat_inc(run_drops_ff);
         if (up_gap > run_longest_ff) begin
            run_longest_next = up_gap;
         end
         span_ms          = up_gap;
         event_res        = EV_REJOIN;
      end else if (is_release) begin
         dropping_in      = 1'b1;
         last_up_in       = now;
         contact_next     = contact_sum[32] ? '1 : contact_sum[31:0];
         event_res        = EV_RELEASE;
      end else if (is_end) begin
         hold_on_in       = 1'b0;
         dropping_in      = 1'b0;
         span_ms          = total;
         event_res        = EV_END;
      end
   end

   assign goal_reached = met;
   assign book.drop    = is_rejoin;
   assign book.run_end = is_end;
   assign book.clean   = met && (run_drops_ff == '0);
   assign book.gap     = up_gap;
   assign book.bin     = gap_bin(up_gap);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_on_ff     <= 1'b0;
         dropping_ff    <= 1'b0;
         run_begin_ff   <= '0;
         contact_ff     <= '0;
         last_down_ff   <= '0;
         last_up_ff     <= '0;
         run_drops_ff   <= '0;
         run_longest_ff <= '0;
      end else if (step) begin
         hold_on_ff     <= hold_on_in;
         dropping_ff    <= dropping_in;
         run_begin_ff   <= run_begin_in;
         contact_ff     <= contact_next;
         last_down_ff   <= last_down_in;
         last_up_ff     <= last_up_in;
         run_drops_ff   <= run_drops_next;
         run_longest_ff <= run_longest_next;
      end
   end

endmodule

### rtl/thd_arm_stats.sv
// ----------------------------------------------------------------------------
// thd_arm_stats
// Per-arm statistics: finished runs, clean runs, dropouts, longest gap and
// the gap histogram, with the live arm's updated values.
// ----------------------------------------------------------------------------
module thd_arm_stats #(
   parameter int NUM_ARMS = 2,
   parameter int ARM_W    = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [ARM_W-1:0]       arm,
   input  thd_pkg::book_type      book,
   output thd_pkg::arm_view_type  view
);
   import thd_pkg::*;

   logic [31:0] runs_ff    [NUM_ARMS];
   logic [31:0] clean_ff   [NUM_ARMS];
   logic [31:0] drops_ff   [NUM_ARMS];
   logic [31:0] longest_ff [NUM_ARMS];
   logic [31:0] hist_ff    [NUM_ARMS][NUM_BINS];
   logic [31:0] hist_cur;

   assign hist_cur = hist_ff[arm][book.bin];

   always_comb begin
      view.runs    = runs_ff[arm];
      view.clean   = clean_ff[arm];
      view.drops   = drops_ff[arm];
      view.longest = longest_ff[arm];
      view.bucket  = '0;
      if (book.run_end) begin
         view.runs = sat_inc(runs_ff[arm]);
         if (book.clean) begin
            view.clean = sat_inc(clean_ff[arm]);
         end
      end
      if (book.drop) begin
         view.drops  = sat_inc(drops_ff[arm]);
         view.bucket = sat_inc(hist_cur);
         if (book.gap > longest_ff[arm]) begin
            view.longest = book.gap;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_ARMS; i++) begin
            runs_ff[i]    <= '0;
            clean_ff[i]   <= '0;
            drops_ff[i]   <= '0;
            longest_ff[i] <= '0;
            for (int j = 0; j < NUM_BINS; j++) begin
               hist_ff[i][j] <= '0;
            end
         end
      end else if (step) begin
         runs_ff[arm]    <= view.runs;
         clean_ff[arm]   <= view.clean;
         drops_ff[arm]   <= view.drops;
         longest_ff[arm] <= view.longest;
         if (book.drop) begin
            hist_ff[arm][book.bin] <= view.bucket;
         end
      end
   end

endmodule
